// File: rtl/pbls_pkg.sv
// pbls_pkg: types and constants shared by the length-field scanner modules
// scan phases, status codes, queue sizing and the event word passed front to back
// no dependencies
`default_nettype none

package pbls_pkg;

    // width of byte offsets; lengths carry one more bit
    localparam int OFFSET_BITS = 24;
    localparam int LEN_BITS    = OFFSET_BITS + 1;

    // field number width taken from the tag
    localparam int FIELD_BITS = 32;

    // varint limits
    localparam int VARINT_MAX  = 10;
    localparam int VCNT_BITS   = 4;
    localparam int VALUE_BITS  = 64;
    localparam int TAG_SHIFT   = 3;

    // fixed field sizes in bytes
    localparam int FIXED64_BYTES = 8;
    localparam int FIXED32_BYTES = 4;

    // event queue sizing, depth is a power of two
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = QPTR_W + 1;

    // wire types
    localparam logic [2:0] WT_VARINT  = 3'd0;
    localparam logic [2:0] WT_FIXED64 = 3'd1;
    localparam logic [2:0] WT_LENGTH  = 3'd2;
    localparam logic [2:0] WT_FIXED32 = 3'd5;

    // end status codes
    localparam logic [2:0] ST_CLEAN    = 3'd0;
    localparam logic [2:0] ST_ZERO_TAG = 3'd1;
    localparam logic [2:0] ST_BAD_WIRE = 3'd2;
    localparam logic [2:0] ST_LONG     = 3'd3;
    localparam logic [2:0] ST_TRUNC    = 3'd4;

    // result kinds
    localparam logic KIND_FIELD = 1'b0;
    localparam logic KIND_END   = 1'b1;

    // scanner phase
    typedef enum logic [2:0] {
        PH_TAG     = 3'd0,
        PH_LEN     = 3'd1,
        PH_VAR     = 3'd2,
        PH_FIXED   = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_STOP    = 3'd5
    } t_phase;

    // what one input byte caused: an optional field result and an optional end result
    typedef struct packed {
        logic                   has_field;
        logic [FIELD_BITS-1:0]  field_number;
        logic [OFFSET_BITS-1:0] payload_offset;
        logic [LEN_BITS-1:0]    payload_length;
        logic                   has_end;
        logic [2:0]             status;
    } t_event;

    // one result word as presented on the output
    typedef struct packed {
        logic                   kind;
        logic [FIELD_BITS-1:0]  field_number;
        logic [OFFSET_BITS-1:0] payload_offset;
        logic [LEN_BITS-1:0]    payload_length;
        logic [2:0]             status;
        logic                   last;
    } t_result;

endpackage

`default_nettype wire

// File: rtl/pbls_front.sv
// pbls_front: byte scanner that walks tags, varints, fixed fields and payloads
// produces one event word per byte that causes results; uses pbls_pkg
`default_nettype none

module pbls_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [7:0]        i_data,
    input  wire logic              i_last,
    input  wire logic              i_q_ready,
    output logic                   o_push,
    output pbls_pkg::t_event       o_evt
);
    import pbls_pkg::*;

    // scanner state
    t_phase                 r_phase,  n_phase;
    logic [VALUE_BITS-1:0]  r_var,    n_var;
    logic [VCNT_BITS-1:0]   r_vbytes, n_vbytes;
    logic [FIELD_BITS-1:0]  r_field,  n_field;
    logic [OFFSET_BITS-1:0] r_pos,    n_pos;
    logic [OFFSET_BITS-1:0] r_pstart, n_pstart;
    logic [LEN_BITS-1:0]    r_skip,   n_skip;
    logic [2:0]             r_stop,   n_stop;

    // state after this byte, before the end-of-buffer reset
    t_phase                 s_phase;
    logic [VALUE_BITS-1:0]  s_var;
    logic [VCNT_BITS-1:0]   s_vbytes;
    logic [FIELD_BITS-1:0]  s_field;
    logic [OFFSET_BITS-1:0] s_pstart;
    logic [LEN_BITS-1:0]    s_skip;
    logic [2:0]             s_stop;

    logic                   accept;
    logic [OFFSET_BITS-1:0] nxt;
    logic [6:0]             v_shamt;
    logic [VALUE_BITS-1:0]  v_new;
    logic [VCNT_BITS-1:0]   v_cnt;
    logic                   v_done;
    logic                   v_long;
    logic [LEN_BITS-1:0]    skip_dec;
    logic [LEN_BITS-1:0]    len_clamp;
    logic                   empty_field;
    logic                   payload_done;
    logic [2:0]             end_status;

    assign o_ready = i_q_ready;
    assign accept  = i_valid && i_q_ready;
    assign nxt     = r_pos + OFFSET_BITS'(1);

    // varint byte merge
    assign v_shamt = 7'(r_vbytes) * 7'd7;
    assign v_new   = (r_vbytes < VCNT_BITS'(VARINT_MAX))
                   ? (r_var | ({{(VALUE_BITS-7){1'b0}}, i_data[6:0]} << v_shamt))
                   : r_var;
    assign v_cnt   = r_vbytes + VCNT_BITS'(1);
    assign v_done  = !i_data[7];
    assign v_long  = i_data[7] && (v_cnt >= VCNT_BITS'(VARINT_MAX));

    // skip countdown and length clamp to the offset range
    assign skip_dec  = (r_skip != '0) ? (r_skip - LEN_BITS'(1)) : r_skip;
    assign len_clamp = (v_new[VALUE_BITS-1:OFFSET_BITS] != '0)
                     ? {1'b1, {OFFSET_BITS{1'b0}}}
                     : {1'b0, v_new[OFFSET_BITS-1:0]};

    assign empty_field  = (r_phase == PH_LEN) && v_done && (v_new == '0);
    assign payload_done = (r_phase == PH_PAYLOAD) && (skip_dec == '0);

    // byte processing
    always_comb begin
        s_phase  = r_phase;
        s_var    = r_var;
        s_vbytes = r_vbytes;
        s_field  = r_field;
        s_pstart = r_pstart;
        s_skip   = r_skip;
        s_stop   = r_stop;
        unique case (r_phase)
            PH_TAG: begin
                s_var    = v_new;
                s_vbytes = v_cnt;
                if (v_long) begin
                    s_phase = PH_STOP;
                    s_stop  = ST_LONG;
                end else if (v_done) begin
                    s_var    = '0;
                    s_vbytes = '0;
                    if (v_new == '0) begin
                        s_phase = PH_STOP;
                        s_stop  = ST_ZERO_TAG;
                    end else begin
                        s_field = v_new[TAG_SHIFT +: FIELD_BITS];
                        priority case (v_new[2:0])
                            WT_LENGTH:  s_phase = PH_LEN;
                            WT_VARINT:  s_phase = PH_VAR;
                            WT_FIXED64: begin
                                s_skip  = LEN_BITS'(FIXED64_BYTES);
                                s_phase = PH_FIXED;
                            end
                            WT_FIXED32: begin
                                s_skip  = LEN_BITS'(FIXED32_BYTES);
                                s_phase = PH_FIXED;
                            end
                            default: begin
                                s_phase = PH_STOP;
                                s_stop  = ST_BAD_WIRE;
                            end
                        endcase
                    end
                end
            end
            PH_LEN: begin
                s_var    = v_new;
                s_vbytes = v_cnt;
                if (v_long) begin
                    s_phase = PH_STOP;
                    s_stop  = ST_LONG;
                end else if (v_done) begin
                    s_var    = '0;
                    s_vbytes = '0;
                    if (v_new == '0) begin
                        s_phase = PH_TAG;
                    end else begin
                        s_skip   = len_clamp;
                        s_pstart = nxt;
                        s_phase  = PH_PAYLOAD;
                    end
                end
            end
            PH_VAR: begin
                s_var    = v_new;
                s_vbytes = v_cnt;
                if (v_long) begin
                    s_phase = PH_STOP;
                    s_stop  = ST_LONG;
                end else if (v_done) begin
                    s_var    = '0;
                    s_vbytes = '0;
                    s_phase  = PH_TAG;
                end
            end
            PH_FIXED: begin
                s_skip = skip_dec;
                if (skip_dec == '0) begin
                    s_phase = PH_TAG;
                end
            end
            PH_PAYLOAD: begin
                s_skip = skip_dec;
                if (skip_dec == '0) begin
                    s_phase = PH_TAG;
                end
            end
            default: begin
                s_phase = r_phase;
            end
        endcase
    end

    // next state: return to reset values after the final byte
    always_comb begin
        n_phase  = r_phase;
        n_var    = r_var;
        n_vbytes = r_vbytes;
        n_field  = r_field;
        n_pos    = r_pos;
        n_pstart = r_pstart;
        n_skip   = r_skip;
        n_stop   = r_stop;
        if (accept) begin
            if (i_last) begin
                n_phase  = PH_TAG;
                n_var    = '0;
                n_vbytes = '0;
                n_field  = '0;
                n_pos    = '0;
                n_pstart = '0;
                n_skip   = '0;
                n_stop   = ST_CLEAN;
            end else begin
                n_phase  = s_phase;
                n_var    = s_var;
                n_vbytes = s_vbytes;
                n_field  = s_field;
                n_pos    = nxt;
                n_pstart = s_pstart;
                n_skip   = s_skip;
                n_stop   = s_stop;
            end
        end
    end

    // end status from the state this byte leaves
    always_comb begin
        if (s_phase == PH_STOP) begin
            end_status = s_stop;
        end else if ((s_phase == PH_TAG) && (s_vbytes == '0)) begin
            end_status = ST_CLEAN;
        end else begin
            end_status = ST_TRUNC;
        end
    end

    // event word for the queue
    always_comb begin
        o_evt                = '0;
        o_evt.has_field      = empty_field || payload_done;
        o_evt.field_number   = r_field;
        o_evt.payload_offset = empty_field ? nxt : r_pstart;
        o_evt.payload_length = empty_field ? '0 : {1'b0, nxt - r_pstart};
        o_evt.has_end        = i_last;
        o_evt.status         = end_status;
        o_push               = accept && (o_evt.has_field || o_evt.has_end);
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_TAG;
            r_var    <= '0;
            r_vbytes <= '0;
            r_field  <= '0;
            r_pos    <= '0;
            r_pstart <= '0;
            r_skip   <= '0;
            r_stop   <= ST_CLEAN;
        end else begin
            r_phase  <= n_phase;
            r_var    <= n_var;
            r_vbytes <= n_vbytes;
            r_field  <= n_field;
            r_pos    <= n_pos;
            r_pstart <= n_pstart;
            r_skip   <= n_skip;
            r_stop   <= n_stop;
        end
    end

    // varint byte count stays below the limit while the scan runs
    a_vbytes_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_STOP) |-> (r_vbytes < VCNT_BITS'(VARINT_MAX)))
        else $error("varint byte count out of range");

    // a stopped scan always carries a failure reason
    a_stop_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_STOP) |->
        ((r_stop == ST_ZERO_TAG) || (r_stop == ST_BAD_WIRE) || (r_stop == ST_LONG)))
        else $error("stopped scan without reason");

    // skip phases always have bytes left to count
    a_skip_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_phase == PH_FIXED) || (r_phase == PH_PAYLOAD)) |-> (r_skip != '0))
        else $error("skip phase with zero count");

endmodule

`default_nettype wire

// File: rtl/pbls_queue.sv
// pbls_queue: small event queue between the scanner and the result emitter
// flip-flop storage of QDEPTH event words; uses pbls_pkg
`default_nettype none

module pbls_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire pbls_pkg::t_event  i_evt,
    output logic                   o_ready,
    input  wire logic              i_pop,
    output logic                   o_valid,
    output pbls_pkg::t_event       o_evt
);
    import pbls_pkg::*;

    t_event             r_mem [QDEPTH];
    logic [QPTR_W-1:0]  r_wr, n_wr;
    logic [QPTR_W-1:0]  r_rd, n_rd;
    logic [QCNT_W-1:0]  r_cnt, n_cnt;
    logic               do_pop;

    assign o_ready = (r_cnt != QCNT_W'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_evt   = r_mem[r_rd];
    assign do_pop  = i_pop && o_valid;

    // pointer and count update
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = r_wr + QPTR_W'(1);
        end
        if (do_pop) begin
            n_rd = r_rd + QPTR_W'(1);
        end
        if (i_push && !do_pop) begin
            n_cnt = r_cnt + QCNT_W'(1);
        end else if (!i_push && do_pop) begin
            n_cnt = r_cnt - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // storage write
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_evt;
        end
    end

    // fill level stays within the depth
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QCNT_W'(QDEPTH))
        else $error("queue count overflow");

    // no word is written while the queue is full
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_cnt != QCNT_W'(QDEPTH)))
        else $error("push into full queue");

    // only words that carry a result are queued
    a_push_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (i_evt.has_field || i_evt.has_end))
        else $error("empty event queued");

endmodule

`default_nettype wire

// File: rtl/pbls_back.sv
// pbls_back: output register that turns each event word into one or two results
// field result first, end result second; uses pbls_pkg
`default_nettype none

module pbls_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_q_valid,
    input  wire pbls_pkg::t_event  i_q_evt,
    output logic                   o_q_pop,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output pbls_pkg::t_result      o_res
);
    import pbls_pkg::*;

    logic    r_valid, n_valid;
    logic    r_fdone, n_fdone;
    t_event  r_evt;
    logic    show_field;
    logic    take;
    logic    finish;

    assign show_field = r_evt.has_field && !r_fdone;
    assign take       = r_valid && i_ready;
    assign finish     = take && !(show_field && r_evt.has_end);
    assign o_q_pop    = i_q_valid && (!r_valid || finish);
    assign o_valid    = r_valid;

    // result word selection
    always_comb begin
        o_res = '0;
        if (show_field) begin
            o_res.kind           = KIND_FIELD;
            o_res.field_number   = r_evt.field_number;
            o_res.payload_offset = r_evt.payload_offset;
            o_res.payload_length = r_evt.payload_length;
            o_res.status         = ST_CLEAN;
            o_res.last           = !r_evt.has_end;
        end else begin
            o_res.kind   = KIND_END;
            o_res.status = r_evt.status;
            o_res.last   = 1'b1;
        end
    end

    // holding register control
    always_comb begin
        n_valid = r_valid;
        n_fdone = r_fdone;
        if (o_q_pop) begin
            n_valid = 1'b1;
            n_fdone = 1'b0;
        end else if (finish) begin
            n_valid = 1'b0;
            n_fdone = 1'b0;
        end else if (take) begin
            n_fdone = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_fdone <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_fdone <= n_fdone;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_evt <= i_q_evt;
        end
    end

    // the field half is marked done only for words that still owe an end result
    a_fdone_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fdone |-> (r_valid && r_evt.has_field && r_evt.has_end))
        else $error("field done flag without pending end result");

    // a held word always has something to show
    a_held_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_evt.has_field || r_evt.has_end))
        else $error("empty word held");

endmodule

`default_nettype wire

// File: rtl/protobuf_length_field_scanner_core.sv
// protobuf_length_field_scanner_core: top level of the length-field scanner
// connects pbls_front, pbls_queue and pbls_back; uses pbls_pkg
//
//   channel   dir  handshake                     payload
//   s_axis    in   s_axis_tvalid/s_axis_tready   tdata: data_byte[7:0]; tlast: last_byte
//   m_axis    out  m_axis_tvalid/m_axis_tready   tdata: field_number, payload_offset,
//                                                payload_length, status; tuser: kind;
//                                                tlast: last_result
//
// one byte is scanned per clock while the event queue has room; the scanner updates its state in the accept cycle
// results reach m_axis through a 4-word event queue and then the pbls_back holding register
// a byte that ends a field on the final byte yields two results, the field result first
// s_axis_tready drops only when the event queue is full
// synchronous active-low reset returns the scanner to tag reading at offset zero
`default_nettype none

module protobuf_length_field_scanner_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic        s_axis_tlast,   // last_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [87:0]      m_axis_tdata,   // [31:0] field_number, [55:32] payload_offset,
                                             // [80:56] payload_length, [83:81] status,
                                             // [87:84] zero
    output logic             m_axis_tuser,   // kind
    output logic             m_axis_tlast    // last_result
);
    import pbls_pkg::*;

    t_event   f_evt;
    logic     f_push;
    logic     q_ready;
    logic     q_valid;
    t_event   q_evt;
    logic     q_pop;
    t_result  b_res;

    // scanner front
    pbls_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_data    (s_axis_tdata),
        .i_last    (s_axis_tlast),
        .i_q_ready (q_ready),
        .o_push    (f_push),
        .o_evt     (f_evt)
    );

    // event queue
    pbls_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_evt   (f_evt),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_evt   (q_evt)
    );

    // result emitter
    pbls_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_evt   (q_evt),
        .o_q_pop   (q_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_res     (b_res)
    );

    // output word packing
    assign m_axis_tdata = {4'b0, b_res.status, b_res.payload_length,
                           b_res.payload_offset, b_res.field_number};
    assign m_axis_tuser = b_res.kind;
    assign m_axis_tlast = b_res.last;

endmodule

`default_nettype wire

// File: sim/protobuf_length_field_scanner_core_test.sv
// protobuf_length_field_scanner_core_test: self-checking bench for the length-field scanner
// streams protobuf byte buffers in, predicts field and end words, checks them in order
// depends on rtl/pbls_pkg.sv and rtl/protobuf_length_field_scanner_core.sv
`default_nettype none

module protobuf_length_field_scanner_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pbls_pkg::*;

    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_PERCENT = 33;
    localparam int MAX_REPORTS  = 10;

    typedef enum int {VARINT_MORE, VARINT_DONE, VARINT_LONG} t_varint_step;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        s_axis_tvalid  = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata   = 8'h00;  // [7:0] data_byte
    logic        s_axis_tlast   = 1'b0;   // last_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready  = 1'b0;
    logic [87:0] m_axis_tdata;            // [31:0] field, [55:32] offset, [80:56] length,
                                          // [83:81] status, [87:84] zero
    logic        m_axis_tuser;            // kind
    logic        m_axis_tlast;            // last_result

    // scanner shadow state
    t_phase                 scan_phase;
    logic [VALUE_BITS-1:0]  acc_value;
    logic [VCNT_BITS-1:0]   acc_bytes;
    logic [FIELD_BITS-1:0]  cur_field;
    logic [OFFSET_BITS-1:0] byte_pos;
    logic [OFFSET_BITS-1:0] pay_start;
    logic [LEN_BITS-1:0]    skip_left;
    logic [2:0]             stop_code;

    t_result     expected_words[$];
    logic [7:0]  msg_q[$];
    int          error_count = 0;
    int          bytes_sent  = 0;
    int          idle_pct    = IDLE_PERCENT;
    logic        hold_toggle = 1'b0;
    logic        hold_seen   = 1'b0;
    int          hold_left   = 0;

    protobuf_length_field_scanner_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------- prediction

    function automatic void clear_scan();
        scan_phase = PH_TAG;
        acc_value  = '0;
        acc_bytes  = '0;
        cur_field  = '0;
        byte_pos   = '0;
        pay_start  = '0;
        skip_left  = '0;
        stop_code  = ST_CLEAN;
    endfunction

    function automatic void halt_scan(input logic [2:0] why);
        scan_phase = PH_STOP;
        stop_code  = why;
    endfunction

    // fold one byte into the varint being read
    function automatic t_varint_step take_varint(input logic [7:0] b);
        if (acc_bytes < VARINT_MAX)
            acc_value |= VALUE_BITS'(b[6:0]) << (7 * acc_bytes);
        acc_bytes++;
        if (!b[7])
            return VARINT_DONE;
        if (acc_bytes >= VARINT_MAX)
            return VARINT_LONG;
        return VARINT_MORE;
    endfunction

    function automatic t_result make_result(input logic kind, input logic [FIELD_BITS-1:0] num,
                                            input logic [OFFSET_BITS-1:0] ofs,
                                            input logic [LEN_BITS-1:0] len,
                                            input logic [2:0] st);
        t_result r;
        r.kind           = kind;
        r.field_number   = num;
        r.payload_offset = ofs;
        r.payload_length = len;
        r.status         = st;
        r.last           = 1'b0;
        return r;
    endfunction

    // advance the shadow scanner by one byte and queue the words it causes
    task automatic scan_byte(input logic [7:0] b, input logic is_last);
        t_result                found[2];
        int                     n;
        t_varint_step           vs;
        logic [VALUE_BITS-1:0]  tag_v;
        logic [OFFSET_BITS-1:0] nxt;
        logic [2:0]             st;
        n   = 0;
        nxt = byte_pos + OFFSET_BITS'(1);
        case (scan_phase)
            PH_TAG: begin
                vs = take_varint(b);
                if (vs == VARINT_LONG) begin
                    halt_scan(ST_LONG);
                end else if (vs == VARINT_DONE) begin
                    tag_v     = acc_value;
                    acc_value = '0;
                    acc_bytes = '0;
                    if (tag_v == 0) begin
                        halt_scan(ST_ZERO_TAG);
                    end else begin
                        cur_field = tag_v[TAG_SHIFT +: FIELD_BITS];
                        case (tag_v[2:0])
                            WT_LENGTH:  scan_phase = PH_LEN;
                            WT_VARINT:  scan_phase = PH_VAR;
                            WT_FIXED64: begin
                                skip_left  = LEN_BITS'(FIXED64_BYTES);
                                scan_phase = PH_FIXED;
                            end
                            WT_FIXED32: begin
                                skip_left  = LEN_BITS'(FIXED32_BYTES);
                                scan_phase = PH_FIXED;
                            end
                            default:    halt_scan(ST_BAD_WIRE);
                        endcase
                    end
                end
            end
            PH_LEN: begin
                vs = take_varint(b);
                if (vs == VARINT_LONG) begin
                    halt_scan(ST_LONG);
                end else if (vs == VARINT_DONE) begin
                    tag_v     = acc_value;
                    acc_value = '0;
                    acc_bytes = '0;
                    if (tag_v == 0) begin
                        // empty payload reported right away
                        found[n] = make_result(KIND_FIELD, cur_field, nxt, '0, ST_CLEAN);
                        n++;
                        scan_phase = PH_TAG;
                    end else begin
                        // oversize lengths saturate so only truncation can end them
                        if (tag_v >= (VALUE_BITS'(1) << OFFSET_BITS))
                            skip_left = LEN_BITS'(1) << OFFSET_BITS;
                        else
                            skip_left = tag_v[LEN_BITS-1:0];
                        pay_start  = nxt;
                        scan_phase = PH_PAYLOAD;
                    end
                end
            end
            PH_VAR: begin
                vs = take_varint(b);
                if (vs == VARINT_LONG) begin
                    halt_scan(ST_LONG);
                end else if (vs == VARINT_DONE) begin
                    acc_value  = '0;
                    acc_bytes  = '0;
                    scan_phase = PH_TAG;
                end
            end
            PH_FIXED: begin
                if (skip_left != 0)
                    skip_left--;
                if (skip_left == 0)
                    scan_phase = PH_TAG;
            end
            PH_PAYLOAD: begin
                if (skip_left != 0)
                    skip_left--;
                if (skip_left == 0) begin
                    found[n] = make_result(KIND_FIELD, cur_field, pay_start,
                                           LEN_BITS'(OFFSET_BITS'(nxt - pay_start)), ST_CLEAN);
                    n++;
                    scan_phase = PH_TAG;
                end
            end
            default: ;
        endcase

        // final byte closes the buffer with a status word
        if (is_last) begin
            if (scan_phase == PH_STOP)
                st = stop_code;
            else if (scan_phase == PH_TAG && acc_bytes == 0)
                st = ST_CLEAN;
            else
                st = ST_TRUNC;
            found[n] = make_result(KIND_END, '0, '0, '0, st);
            n++;
            clear_scan();
        end else begin
            byte_pos = nxt;
        end

        if (n > 0)
            found[n-1].last = 1'b1;
        for (int i = 0; i < n; i++)
            expected_words.insert(expected_words.size(), found[i]);
    endtask

    // ---------------------------------------------------------------- checking

    function automatic void log_mismatch(input string what, input t_result want,
                                         input t_result got);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            $display("%s: expected kind=%0d field=%0d ofs=%0d len=%0d st=%0d last=%0d",
                     what, want.kind, want.field_number, want.payload_offset,
                     want.payload_length, want.status, want.last);
            $display("%s: got      kind=%0d field=%0d ofs=%0d len=%0d st=%0d last=%0d",
                     what, got.kind, got.field_number, got.payload_offset,
                     got.payload_length, got.status, got.last);
        end
    endfunction

    task automatic check_word();
        t_result want;
        t_result got;
        got.kind           = m_axis_tuser;
        got.field_number   = m_axis_tdata[31:0];
        got.payload_offset = m_axis_tdata[55:32];
        got.payload_length = m_axis_tdata[80:56];
        got.status         = m_axis_tdata[83:81];
        got.last           = m_axis_tlast;
        if (expected_words.size() == 0) begin
            log_mismatch("unexpected word", '0, got);
        end else begin
            want = expected_words.pop_front();
            if (got != want)
                log_mismatch("word mismatch", want, got);
        end
    endtask

    // accepted input bytes feed the shadow scanner, accepted output words are checked
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_scan();
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                scan_byte(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
                check_word();
        end
    end

    // output side: random back-pressure plus a long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            hold_left     <= 0;
            hold_seen     <= hold_toggle;
        end else if (hold_toggle != hold_seen) begin
            hold_seen     <= hold_toggle;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // ---------------------------------------------------------------- stimulus

    // add one byte at the tail of the message being built
    function automatic void append_byte(input logic [7:0] b);
        msg_q.insert(msg_q.size(), b);
    endfunction

    // offer one byte, with random gaps ahead of it, and wait until it is taken
    task automatic send_byte(input logic [7:0] d, input logic is_last);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tlast  <= is_last;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
    endtask

    task automatic send_buffer();
        while (msg_q.size() != 0) begin
            send_byte(msg_q[0], msg_q.size() == 1);
            void'(msg_q.pop_front());
            bytes_sent++;
        end
    endtask

    // sender pauses until every predicted word has come out
    task automatic drain_words();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_words.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic [63:0] rand_bits(input int n);
        return {$urandom, $urandom} >> (64 - n);
    endfunction

    // varint encoding, optionally padded with redundant continuation groups
    task automatic add_varint(input logic [63:0] v, input bit padded);
        int          len;
        int          span;
        logic [63:0] rest;
        len  = 1;
        rest = v >> 7;
        while (rest != 0) begin
            len++;
            rest = rest >> 7;
        end
        span = padded ? $urandom_range(VARINT_MAX, len) : len;
        for (int i = 0; i < span; i++)
            append_byte({1'(i < span - 1), 7'((v >> (7 * i)) & 64'h7f)});
    endtask

    function automatic logic [63:0] rand_field_number();
        int pick;
        pick = $urandom_range(99);
        if (pick < 70)
            return 64'($urandom_range(40, 1));
        if (pick < 90)
            return {32'h0, $urandom};
        return rand_bits(61);
    endfunction

    // one well-formed field of random wire type and content
    task automatic add_field();
        logic [2:0]  wtype;
        logic [63:0] len;
        int          pick;
        case ($urandom_range(3))
            0:       wtype = WT_VARINT;
            1:       wtype = WT_FIXED64;
            2:       wtype = WT_LENGTH;
            default: wtype = WT_FIXED32;
        endcase
        add_varint((rand_field_number() << TAG_SHIFT) | 64'(wtype), $urandom_range(9) == 0);
        case (wtype)
            WT_VARINT:
                add_varint(rand_bits($urandom_range(64, 1)), $urandom_range(9) == 0);
            WT_FIXED64:
                repeat (FIXED64_BYTES) append_byte(8'($urandom));
            WT_FIXED32:
                repeat (FIXED32_BYTES) append_byte(8'($urandom));
            default: begin
                pick = $urandom_range(99);
                if (pick < 20)
                    len = 64'h0;
                else if (pick < 90)
                    len = 64'($urandom_range(8, 1));
                else
                    len = 64'($urandom_range(40, 9));
                add_varint(len, $urandom_range(9) == 0);
                repeat (len) append_byte(8'($urandom));
            end
        endcase
    endtask

    task automatic build_message(input int fields);
        msg_q.delete();
        repeat (fields) add_field();
    endtask

    // a tail that stops the scan or leaves it cut short
    task automatic add_breakage();
        logic [63:0] fnum;
        fnum = rand_field_number();
        case ($urandom_range(5))
            0: add_varint(64'h0, $urandom_range(1) == 0);
            1: begin
                case ($urandom_range(3))
                    0:       add_varint((fnum << TAG_SHIFT) | 64'd3, 1'b0);
                    1:       add_varint((fnum << TAG_SHIFT) | 64'd4, 1'b0);
                    2:       add_varint((fnum << TAG_SHIFT) | 64'd6, 1'b0);
                    default: add_varint((fnum << TAG_SHIFT) | 64'd7, 1'b0);
                endcase
            end
            2: repeat ($urandom_range(12, VARINT_MAX)) append_byte(8'($urandom) | 8'h80);
            3: begin
                add_varint((fnum << TAG_SHIFT) | 64'(WT_LENGTH), 1'b0);
                repeat (VARINT_MAX) append_byte(8'($urandom) | 8'h80);
            end
            4: begin
                add_varint((fnum << TAG_SHIFT) | 64'(WT_VARINT), 1'b0);
                repeat (VARINT_MAX) append_byte(8'($urandom) | 8'h80);
            end
            default: begin
                // length of 2^24 or more
                add_varint((fnum << TAG_SHIFT) | 64'(WT_LENGTH), 1'b0);
                add_varint(64'h100_0000 | rand_bits($urandom_range(64, 1)), 1'b0);
                repeat ($urandom_range(6)) append_byte(8'($urandom));
            end
        endcase
    endtask

    // ---------------------------------------------------------------- tests

    // hand-picked buffers for the corner cases
    task automatic test_special_cases();
        // empty payload on the final byte: field word then end word
        msg_q.delete();
        append_byte(8'h12);
        append_byte(8'h00);
        send_buffer();
        // one-byte payload ending on the final byte
        append_byte(8'h0A);
        append_byte(8'h01);
        append_byte(8'hFF);
        send_buffer();
        // zero tag
        append_byte(8'h00);
        send_buffer();
        // bad wire type, then a byte that is only counted
        append_byte(8'h0B);
        append_byte(8'h55);
        send_buffer();
        // buffer cut inside a tag, then inside a varint field
        append_byte(8'h80);
        send_buffer();
        append_byte(8'h08);
        append_byte(8'h80);
        send_buffer();
        // fixed32 field with extreme data bytes
        append_byte(8'h0D);
        append_byte(8'h00);
        append_byte(8'hFF);
        append_byte(8'h00);
        append_byte(8'hFF);
        send_buffer();
        // over-long tag varint
        repeat (VARINT_MAX) append_byte(8'hFF);
        send_buffer();
    endtask

    // mostly well-formed messages, some cut short or broken
    task automatic test_random_messages(input int budget);
        int stop_at;
        int pick;
        int keep;
        stop_at = bytes_sent + budget;
        while (bytes_sent < stop_at) begin
            build_message($urandom_range(6, 1));
            pick = $urandom_range(99);
            if (pick >= 75 && pick < 87 && msg_q.size() > 1) begin
                keep = $urandom_range(msg_q.size() - 1, 1);
                while (msg_q.size() > keep)
                    msg_q.delete(msg_q.size() - 1);
            end else if (pick >= 87) begin
                add_breakage();
                repeat ($urandom_range(3)) append_byte(8'($urandom));
            end
            send_buffer();
        end
    endtask

    // back-to-back traffic with no idling on either side
    task automatic test_steady_stream(input int budget);
        idle_pct <= 0;
        @(posedge i_clk);
        test_random_messages(budget);
        drain_words();
        idle_pct <= IDLE_PERCENT;
    endtask

    // output held off while dense field words pile up and stall the input
    task automatic test_output_stall();
        hold_toggle <= ~hold_toggle;
        msg_q.delete();
        repeat (40) begin
            add_varint((rand_field_number() << TAG_SHIFT) | 64'(WT_LENGTH), 1'b0);
            append_byte(8'h00);
        end
        send_buffer();
    endtask

    // random noise buffers and broken messages
    task automatic test_broken_messages(input int budget);
        int stop_at;
        stop_at = bytes_sent + budget;
        while (bytes_sent < stop_at) begin
            if ($urandom_range(99) < 40) begin
                msg_q.delete();
                repeat ($urandom_range(12, 1)) append_byte(8'($urandom));
            end else begin
                build_message($urandom_range(2));
                add_breakage();
                repeat ($urandom_range(4)) append_byte(8'($urandom));
            end
            send_buffer();
        end
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_special_cases();
        drain_words();
        test_random_messages(1150);
        drain_words();
        test_steady_stream(300);
        test_output_stall();
        drain_words();
        test_broken_messages(200);
        drain_words();

        repeat (20) @(posedge i_clk);
        if (error_count == 0)
            $display("protobuf_length_field_scanner_core_test: PASS");
        else
            $display("protobuf_length_field_scanner_core_test: FAIL");
        $finish;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("protobuf_length_field_scanner_core_test: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
